// ===== sv/assert_macros.svh =====
// Assertion macros used by the top level of the indentation tokenizer.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// A condition that implies another at the same edge.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// A condition that implies another at the next edge.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/idt_pkg.sv =====
// Package of the indentation tokenizer: token codes, stack sizes and the
// stack command struct. It depends on nothing.
package idt_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int INDENT_BITS = 8;
  localparam int COUNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    TOK_INDENT = 2'd0,
    TOK_DEDENT = 2'd1,
    TOK_LINE   = 2'd2,
    TOK_ERROR  = 2'd3
  } tok_e;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_cmd_t;

endpackage

// ===== sv/indent_dedent_tokenizer_core.sv =====
// Top level of the indentation tokenizer: request sequencer, output register
// and the chain of idt_cell stack cells. Uses idt_pkg and assert_macros.svh.
//
// Each request carries one source line's indentation or an end-of-input mark
// and yields one token per cycle while out_stall_i does not hold the output
// register, the last one flagged by last_o. The level stack is a row of
// STACK_DEPTH cells with the top in cell zero; one push or pop per cycle shifts
// the whole row, which sets the one-DEDENT-per-cycle pace. A new request is
// taken only when the previous one has yielded all its tokens, while its final
// token may still wait in the output register.
`include "assert_macros.svh"

module indent_dedent_tokenizer_core
  import idt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [7:0] indent_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] token_o,
  output logic       last_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                   state_q, state_d;
  logic                   kind_q;
  logic [INDENT_BITS-1:0] ind_q;
  logic                   lead_q, lead_d;
  logic                   dedent_q, dedent_d;
  logic                   started_q, started_d;
  logic [COUNT_W-1:0]     count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  tok_e                   token_q, tok;
  logic                   last_q, last;
  logic                   done;
  logic                   fire;
  logic                   in_acc;
  stack_cmd_t             cmd;
  logic [INDENT_BITS-1:0] level [STACK_DEPTH];
  logic [INDENT_BITS-1:0] top;

  assign in_acc = in_valid_i && !in_stall_o;
  assign fire   = (state_q == ST_RUN) && (!out_valid_q || !out_stall_i);
  assign top    = level[0];

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic [INDENT_BITS-1:0] above, below;
    if (g == 0) begin : g_top
      assign above = ind_q;
    end else begin : g_mid
      assign above = level[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_inner
      assign below = level[g+1];
    end
    idt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .above_i (above),
      .below_i (below),
      .level_o (level[g])
    );
  end

  always_comb begin
    tok       = TOK_LINE;
    last      = 1'b0;
    done      = 1'b0;
    cmd       = '0;
    count_d   = count_q;
    lead_d    = lead_q;
    dedent_d  = dedent_q;
    started_d = started_q;
    if (fire) begin
      if (lead_q) begin
        tok       = TOK_INDENT;
        lead_d    = 1'b0;
        started_d = 1'b1;
      end else if (kind_q) begin
        tok = TOK_DEDENT;
        if (count_q == COUNT_W'(1)) begin
          last      = 1'b1;
          done      = 1'b1;
          started_d = 1'b0;
        end else begin
          cmd.pop = 1'b1;
          count_d = count_q - COUNT_W'(1);
        end
      end else if (ind_q == top) begin
        tok  = TOK_LINE;
        last = 1'b1;
        done = 1'b1;
      end else if (ind_q > top) begin
        if (!dedent_q && (count_q < COUNT_W'(STACK_DEPTH))) begin
          tok      = TOK_INDENT;
          cmd.push = 1'b1;
          count_d  = count_q + COUNT_W'(1);
        end else begin
          tok  = TOK_ERROR;
          last = 1'b1;
          done = 1'b1;
        end
      end else begin
        if (count_q > COUNT_W'(1)) begin
          tok      = TOK_DEDENT;
          cmd.pop  = 1'b1;
          count_d  = count_q - COUNT_W'(1);
          dedent_d = 1'b1;
        end else begin
          tok  = TOK_ERROR;
          last = 1'b1;
          done = 1'b1;
        end
      end
    end
    if (in_acc) begin
      lead_d   = !started_q;
      dedent_d = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lead_q      <= 1'b0;
      dedent_q    <= 1'b0;
      started_q   <= 1'b0;
      count_q     <= COUNT_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lead_q      <= lead_d;
      dedent_q    <= dedent_d;
      started_q   <= started_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= kind_i;
      ind_q  <= INDENT_BITS'(indent_i);
    end
    if (fire) begin
      token_q <= tok;
      last_q  <= last;
    end
  end

  assign in_stall_o  = (state_q == ST_RUN);
  assign out_valid_o = out_valid_q;
  assign token_o     = token_q;
  assign last_o      = last_q;

  `ASSERT_ALWAYS(a_count_range, (count_q != '0) && (count_q <= COUNT_W'(STACK_DEPTH)))
  `ASSERT_IMPLIES(a_push_room, cmd.push, count_q < COUNT_W'(STACK_DEPTH))
  `ASSERT_IMPLIES(a_pop_base, cmd.pop, count_q > COUNT_W'(1))
  `ASSERT_NEXT(a_end_resets, fire && kind_q && last, (count_q == COUNT_W'(1)) && !started_q)
  `ASSERT_IMPLIES(a_done_last, fire, done == last)

endmodule

// ===== sv/idt_cell.sv =====
// One cell of the indentation level stack. It holds one level and shifts
// toward the bottom on a push and toward the top on a pop. Uses idt_pkg.
module idt_cell
  import idt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stack_cmd_t             cmd_i,
  input  logic [INDENT_BITS-1:0] above_i,
  input  logic [INDENT_BITS-1:0] below_i,
  output logic [INDENT_BITS-1:0] level_o
);

  logic [INDENT_BITS-1:0] level_q, level_d;

  always_comb begin
    level_d = level_q;
    if (cmd_i.push) begin
      level_d = above_i;
    end else if (cmd_i.pop) begin
      level_d = below_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;

endmodule
